[rtl/core/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 32;
    localparam int DATA_W    = 32;
    localparam int USE_W     = 16;
    localparam int AGE_W     = 32;
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;
    localparam logic [USE_W-1:0] USE_MAX = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // one memory word per slot
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [USE_W-1:0]  use_cnt;
        logic [AGE_W-1:0]  last_use;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_VREAD,
        ST_WRITE,
        ST_OUT
    } state_t;

endpackage

[rtl/core/lfu_cache.sv]
// ----------------------------------------------------------------------------
// lfu_cache
// LFU key-value cache with LRU tie break, entries held in one sync RAM.
// Every item scans all entries; a miss or ignored put then goes straight to the result,
// an insert into a free slot writes first, and a hit or an eviction reads back, then writes.
// One item in flight; next item accepted the cycle after the result is taken.
// The scan reads one RAM word per cycle; that read port sets the rate.
// Reset clears valid bits, occupancy, tick and capacity (to 16); no RAM sweep.
// ----------------------------------------------------------------------------
module lfu_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd[0], key[32:1], value[64:33], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // hit[0], read_value[32:1], evicted[33],
                                   // evicted_key[65:34], zero pad
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    lfu_pkg::entry_t mem [lfu_pkg::ENTRIES];
    lfu_pkg::entry_t rd_q;
    logic                     rd_en;
    logic [lfu_pkg::IDX_W-1:0] rd_addr;
    logic                     wr_en;
    logic [lfu_pkg::IDX_W-1:0] wr_addr;
    lfu_pkg::entry_t          wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    lfu_pkg::state_t state_reg, state_next;
    logic [lfu_pkg::ENTRIES-1:0] valid_reg, valid_next;
    logic [lfu_pkg::CNT_W-1:0]   occ_reg, occ_next;
    logic [lfu_pkg::AGE_W-1:0]   tick_reg, tick_next;
    logic [lfu_pkg::CAP_W-1:0]   cap_reg;
    logic [lfu_pkg::CNT_W:0]     ptr_reg, ptr_next;   // read address counter
    logic                        cmd_reg, cmd_next;
    logic [31:0]                 key_reg, key_next, val_reg, val_next;
    logic                        hit_reg, hit_next;
    logic [lfu_pkg::IDX_W-1:0]   hidx_reg, hidx_next;
    logic                        vfound_reg, vfound_next;
    logic [lfu_pkg::IDX_W-1:0]   vidx_reg, vidx_next;
    logic [lfu_pkg::USE_W-1:0]   vcnt_reg, vcnt_next;
    logic [lfu_pkg::AGE_W-1:0]   vage_reg, vage_next;
    logic                        hitout_reg, hitout_next, ev_reg, ev_next;
    logic [31:0]                 rv_reg, rv_next, ek_reg, ek_next;
    logic                        wr_ins_reg, wr_ins_next;
    logic [lfu_pkg::IDX_W-1:0]   widx_reg, widx_next;

    logic [lfu_pkg::IDX_W-1:0] scan_idx;
    logic                      scan_v;
    logic [lfu_pkg::AGE_W-1:0] age;
    logic [lfu_pkg::CNT_W-1:0] cap_eff;
    logic                      free_found;
    logic [lfu_pkg::IDX_W-1:0] free_idx;
    logic [lfu_pkg::USE_W-1:0] cnt_inc;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = lfu_pkg::IDX_W'(i);
            end
        end
    end

    assign cap_eff  = (32'(cap_reg) > 32'(lfu_pkg::ENTRIES)) ?
                      lfu_pkg::CNT_W'(lfu_pkg::ENTRIES) : lfu_pkg::CNT_W'(cap_reg);
    assign scan_idx = ptr_reg[lfu_pkg::IDX_W-1:0] - lfu_pkg::IDX_W'(1);
    assign scan_v   = valid_reg[scan_idx];
    assign age      = tick_reg - rd_q.last_use;
    assign cnt_inc  = (rd_q.use_cnt == lfu_pkg::USE_MAX) ? rd_q.use_cnt
                                                        : rd_q.use_cnt + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
            valid_reg <= '0;
            occ_reg   <= '0;
            tick_reg  <= '0;
            cap_reg   <= lfu_pkg::CAP_W'(lfu_pkg::CAP_RESET);
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            tick_reg  <= tick_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        vfound_reg <= vfound_next;
        vidx_reg   <= vidx_next;
        vcnt_reg   <= vcnt_next;
        vage_reg   <= vage_next;
        hitout_reg <= hitout_next;
        ev_reg     <= ev_next;
        rv_reg     <= rv_next;
        ek_reg     <= ek_next;
        wr_ins_reg <= wr_ins_next;
        widx_reg   <= widx_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        occ_next    = occ_reg;
        tick_next   = tick_reg;
        ptr_next    = ptr_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        hit_next    = hit_reg;
        hidx_next   = hidx_reg;
        vfound_next = vfound_reg;
        vidx_next   = vidx_reg;
        vcnt_next   = vcnt_reg;
        vage_next   = vage_reg;
        hitout_next = hitout_reg;
        ev_next     = ev_reg;
        rv_next     = rv_reg;
        ek_next     = ek_reg;
        wr_ins_next = wr_ins_reg;
        widx_next   = widx_reg;
        rd_en       = 1'b0;
        rd_addr     = ptr_reg[lfu_pkg::IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = widx_reg;
        wr_data     = rd_q;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;

        case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd_next    = s_tdata[0];
                    key_next    = s_tdata[32:1];
                    val_next    = s_tdata[64:33];
                    hit_next    = 1'b0;
                    vfound_next = 1'b0;
                    rd_en       = 1'b1;
                    rd_addr     = '0;
                    ptr_next    = (lfu_pkg::CNT_W+1)'(1);
                    state_next  = lfu_pkg::ST_SCAN;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                // rd_q holds entry ptr-1; look for key and track victim
                if (scan_v)
                begin
                    if (!hit_reg && rd_q.key == key_reg)
                    begin
                        hit_next  = 1'b1;
                        hidx_next = scan_idx;
                    end
                    if (!vfound_reg || rd_q.use_cnt < vcnt_reg ||
                        (rd_q.use_cnt == vcnt_reg && age > vage_reg))
                    begin
                        vfound_next = 1'b1;
                        vidx_next   = scan_idx;
                        vcnt_next   = rd_q.use_cnt;
                        vage_next   = age;
                    end
                end
                if (32'(ptr_reg) == 32'(lfu_pkg::ENTRIES))
                begin
                    state_next = lfu_pkg::ST_DECIDE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            lfu_pkg::ST_DECIDE:
            begin
                hitout_next = 1'b0;
                ev_next     = 1'b0;
                rv_next     = '0;
                ek_next     = '0;
                wr_ins_next = 1'b0;
                state_next  = lfu_pkg::ST_OUT;
                if (cmd_reg == lfu_pkg::CMD_GET || cap_eff != '0 || hit_reg)
                begin
                    if (hit_reg && (cmd_reg == lfu_pkg::CMD_GET || cap_eff != '0))
                    begin
                        hitout_next = 1'b1;
                        widx_next   = hidx_reg;
                        rd_en       = 1'b1;
                        rd_addr     = hidx_reg;
                        state_next  = lfu_pkg::ST_VREAD;
                    end
                    else if (cmd_reg == lfu_pkg::CMD_PUT && !hit_reg)
                    begin
                        wr_ins_next = 1'b1;
                        state_next  = lfu_pkg::ST_WRITE;
                        if ((occ_reg >= cap_eff || !free_found) && vfound_reg)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = vidx_reg;
                            widx_next  = vidx_reg;
                            ev_next    = 1'b1;
                            state_next = lfu_pkg::ST_VREAD;
                        end
                        else if (free_found)
                        begin
                            widx_next = free_idx;
                        end
                        else
                        begin
                            wr_ins_next = 1'b0;
                            state_next  = lfu_pkg::ST_OUT;
                        end
                    end
                end
            end
            lfu_pkg::ST_VREAD:
            begin
                // wait for the entry to come back out of the RAM
                state_next = lfu_pkg::ST_WRITE;
            end
            lfu_pkg::ST_WRITE:
            begin
                wr_en     = 1'b1;
                tick_next = tick_reg + 1'b1;
                if (wr_ins_reg)
                begin
                    if (ev_reg)
                    begin
                        ek_next = rd_q.key;
                    end
                    else
                    begin
                        occ_next = occ_reg + 1'b1;
                    end
                    wr_data.key      = key_reg;
                    wr_data.data     = val_reg;
                    wr_data.use_cnt  = lfu_pkg::USE_W'(1);
                    wr_data.last_use = tick_reg + 1'b1;
                    valid_next[widx_reg] = 1'b1;
                end
                else
                begin
                    wr_data.use_cnt  = cnt_inc;
                    wr_data.last_use = tick_reg + 1'b1;
                    if (cmd_reg == lfu_pkg::CMD_GET)
                    begin
                        rv_next = rd_q.data;
                    end
                    else
                    begin
                        wr_data.data = val_reg;
                    end
                end
                state_next = lfu_pkg::ST_OUT;
            end
            lfu_pkg::ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = lfu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tdata = {6'd0, ek_reg, ev_reg, rv_reg, hitout_reg};

endmodule
